/* sv/issc_pkg.sv */
// shared types and constants for the inactivity sleep state controller
package issc_pkg;

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam int TIME_W = 32;
    localparam int KICK_W = 8;

    localparam logic [DATA_W-1:0] IDLE_TIMEOUT_RESET  = 32'd5000;
    localparam logic [DATA_W-1:0] LIGHT_TIMEOUT_RESET = 32'd30000;
    localparam logic [KICK_W-1:0] KICK_PERIOD_RESET   = 8'd50;

    typedef enum logic [1:0] {
        REG_IDLE_TIMEOUT  = 2'd0,
        REG_LIGHT_TIMEOUT = 2'd1,
        REG_KICK_PERIOD   = 2'd2
    } reg_index_t;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_WAKE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        PS_IDLE  = 2'd0,
        PS_LIGHT = 2'd1,
        PS_DEEP  = 2'd2
    } power_state_t;

endpackage

/* sv/inactivity_sleep_state_controller.sv */
// top level: inactivity sleep state controller with apb configuration
// path: an item is captured in the input register on acceptance and its result is
// registered in the result register when the item fires, which a stalled output holds off
// throughput: one item per cycle while the output is not stalled; the state update between
// the input register and the result register is combinational
// reset: asynchronous active-low; state idle, timestamps, head and counters zero,
// registers back to 5000, 30000 and 50
module inactivity_sleep_state_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [issc_pkg::ADDR_W-1:0]   paddr,
    input  logic [issc_pkg::DATA_W-1:0]   pwdata,
    output logic [issc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic [issc_pkg::TIME_W-1:0]   now_ms,
    input  logic [issc_pkg::TIME_W-1:0]   rx_head,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    pwr_state,
    output logic                          enter_light,
    output logic                          enter_deep,
    output logic                          exit_light,
    output logic                          exit_deep,
    output logic                          wd_kick,
    output logic [issc_pkg::TIME_W-1:0]   idle_ms
);
    import issc_pkg::*;

    // configuration registers
    logic [TIME_W-1:0] idle_timeout_reg;
    logic [TIME_W-1:0] light_timeout_reg;
    logic [KICK_W-1:0] kick_period_reg;
    logic              cfg_write;
    reg_index_t        cfg_index;

    // input register
    logic              in_valid_reg;
    logic              in_op_reg;
    logic [TIME_W-1:0] in_now_reg;
    logic [TIME_W-1:0] in_head_reg;

    // block state
    power_state_t      state_reg, state_next;
    logic [TIME_W-1:0] last_act_reg, last_act_next;
    logic [TIME_W-1:0] last_head_reg, last_head_next;
    logic [KICK_W-1:0] quiet_reg, quiet_next;
    logic              wake_reg, wake_next;

    // result register
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        res_state_reg;
    logic              res_el_reg, res_ed_reg, res_xl_reg, res_xd_reg, res_kick_reg;
    logic [TIME_W-1:0] res_idle_reg;

    logic              fire;
    logic              res_el, res_ed, res_xl, res_xd, res_kick;
    logic [TIME_W-1:0] idle_time;
    logic              activity;
    logic [KICK_W:0]   kick_limit;
    logic [KICK_W:0]   quiet_inc;
    logic              wrap;

    assign pready    = 1'b1;
    assign cfg_index = reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg  <= IDLE_TIMEOUT_RESET;
            light_timeout_reg <= LIGHT_TIMEOUT_RESET;
            kick_period_reg   <= KICK_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_IDLE_TIMEOUT:  idle_timeout_reg  <= pwdata;
                REG_LIGHT_TIMEOUT: light_timeout_reg <= pwdata;
                REG_KICK_PERIOD:   kick_period_reg   <= pwdata[KICK_W-1:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_index)
            REG_IDLE_TIMEOUT:  prdata = idle_timeout_reg;
            REG_LIGHT_TIMEOUT: prdata = light_timeout_reg;
            REG_KICK_PERIOD:   prdata = {{(DATA_W-KICK_W){1'b0}}, kick_period_reg};
            default:           prdata = '0;
        endcase
    end

    // handshake
    assign fire     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_op_reg   <= op;
            in_now_reg  <= now_ms;
            in_head_reg <= rx_head;
        end
    end

    // step logic
    assign idle_time  = in_now_reg - last_act_reg;
    assign activity   = in_head_reg != last_head_reg;
    assign kick_limit = (kick_period_reg == '0) ? (KICK_W+1)'(1 << KICK_W)
                                                : {1'b0, kick_period_reg};
    assign quiet_inc  = {1'b0, quiet_reg} + (KICK_W+1)'(1);
    assign wrap       = quiet_inc >= kick_limit;

    always_comb
    begin
        state_next     = state_reg;
        last_act_next  = last_act_reg;
        last_head_next = last_head_reg;
        quiet_next     = quiet_reg;
        wake_next      = wake_reg;
        res_el         = 1'b0;
        res_ed         = 1'b0;
        res_xl         = 1'b0;
        res_xd         = 1'b0;
        res_kick       = 1'b0;
        if (fire)
        begin
            if (op_t'(in_op_reg) == OP_WAKE)
            begin
                wake_next = 1'b1;
            end
            else
            begin
                last_head_next = in_head_reg;
                if (wake_reg || activity)
                begin
                    wake_next     = 1'b0;
                    state_next    = PS_IDLE;
                    quiet_next    = '0;
                    last_act_next = in_now_reg;
                    case (state_reg)
                        PS_DEEP:
                        begin
                            res_xd   = 1'b1;
                            res_kick = 1'b1;
                        end
                        PS_LIGHT: res_xl = 1'b1;
                        default:  ;
                    endcase
                end
                else
                begin
                    quiet_next = wrap ? '0 : quiet_inc[KICK_W-1:0];
                    case (state_reg)
                        PS_IDLE:
                        begin
                            if (idle_time >= idle_timeout_reg)
                            begin
                                state_next = PS_LIGHT;
                                quiet_next = '0;
                                res_el     = 1'b1;
                            end
                        end
                        PS_LIGHT:
                        begin
                            if (idle_time >= light_timeout_reg)
                            begin
                                state_next = PS_DEEP;
                                quiet_next = '0;
                                res_ed     = 1'b1;
                            end
                        end
                        PS_DEEP:  res_kick = wrap;
                        default:  state_next = PS_IDLE;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PS_IDLE;
            last_act_reg  <= '0;
            last_head_reg <= '0;
            quiet_reg     <= '0;
            wake_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_act_reg  <= last_act_next;
            last_head_reg <= last_head_next;
            quiet_reg     <= quiet_next;
            wake_reg      <= wake_next;
        end
    end

    // result register
    assign out_valid_next = fire || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_state_reg <= state_next;
            res_el_reg    <= res_el;
            res_ed_reg    <= res_ed;
            res_xl_reg    <= res_xl;
            res_xd_reg    <= res_xd;
            res_kick_reg  <= res_kick;
            res_idle_reg  <= in_now_reg - last_act_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pwr_state   = res_state_reg;
    assign enter_light = res_el_reg;
    assign enter_deep  = res_ed_reg;
    assign exit_light  = res_xl_reg;
    assign exit_deep   = res_xd_reg;
    assign wd_kick     = res_kick_reg;
    assign idle_ms     = res_idle_reg;

    // checks
    a_pulse_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $onehot0({enter_light, enter_deep, exit_light, exit_deep}))
        else $error("more than one state change pulse in one item");

    a_deep_exit_kick: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && exit_deep |-> wd_kick && pwr_state == PS_IDLE)
        else $error("deep exit without watchdog kick or not back to idle");

    a_wake_pending: assert property (@(posedge clk) disable iff (!rst_n)
        fire && op_t'(in_op_reg) == OP_WAKE |=> wake_reg && $stable(state_reg))
        else $error("wake item did not leave a pending wake alone");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !out_ready |=> in_valid_reg && out_valid_reg)
        else $error("item lost while output stalled");

endmodule
